### rtl/sorted_table_insert_remove_search_top_assert.svh
// Assertion macros shared by the sorted table RTL.
// Define NO_ASSERTIONS to compile every macro to nothing.
`ifndef SORTED_TABLE_INSERT_REMOVE_SEARCH_TOP_ASSERT_SVH
`define SORTED_TABLE_INSERT_REMOVE_SEARCH_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is held
`define STSR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stsr: same-cycle check failed");
// Next-cycle implication, disabled while reset is held
`define STSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stsr: next-cycle check failed");
`else
`define STSR_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define STSR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/stsr_pkg.sv
// Package for the sorted table: sizes, operation codes and the structs
// passed between the controller and the cell chain. No dependencies.
package stsr_pkg;

    localparam int CAPACITY    = 128;
    localparam int IW          = $clog2(CAPACITY);
    localparam int CW          = $clog2(CAPACITY + 1);
    localparam int KEY_W       = 32;
    localparam int POS_W       = 7;
    localparam int CNT_W       = 8;
    localparam int GROUP_SIZE  = 16;
    localparam int NUM_GROUPS  = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic                    shift_ins;
        logic                    shift_rem;
        logic signed [KEY_W-1:0] key;
        logic signed [KEY_W-1:0] value;
        logic [POS_W-1:0]        pos;
        logic [CW-1:0]           count;
        logic [IW-1:0]           mid;
    } t_bcast;

    // Per-cell compare flags against the broadcast value
    typedef struct packed {
        logic [CAPACITY-1:0] lt;
        logic [CAPACITY-1:0] gt;
    } t_flags;

    typedef struct packed {
        logic                    ok;
        logic signed [KEY_W-1:0] found_key;
        logic signed [KEY_W-1:0] found_value;
        logic [POS_W-1:0]        found_position;
        logic [CNT_W-1:0]        entry_count;
    } t_result;

endpackage

### rtl/stsr_if.sv
// Handshake interfaces for the sorted table's request and result channels.
// Depends on stsr_pkg for field widths.
interface stsr_in_if;
    import stsr_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [1:0]              op;
    logic signed [KEY_W-1:0] entry_key;
    logic signed [KEY_W-1:0] entry_value;
    logic [POS_W-1:0]        position;

    modport source (output valid, op, entry_key, entry_value, position, input ready);
    modport sink   (input valid, op, entry_key, entry_value, position, output ready);
endinterface

interface stsr_out_if;
    import stsr_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    ok;
    logic signed [KEY_W-1:0] found_key;
    logic signed [KEY_W-1:0] found_value;
    logic [POS_W-1:0]        found_position;
    logic [CNT_W-1:0]        entry_count;

    modport source (output valid, ok, found_key, found_value, found_position, entry_count,
                    input ready);
    modport sink   (input valid, ok, found_key, found_value, found_position, entry_count,
                    output ready);
endinterface

### rtl/stsr_cell.sv
// One table slot: holds a (key, value) pair, compares it with the broadcast
// value and takes its neighbour's pair on insert or remove. Uses stsr_pkg.
module stsr_cell (
    input  logic                            i_clk,
    input  logic [stsr_pkg::IW-1:0]         i_index,
    input  stsr_pkg::t_bcast                i_bcast,
    input  logic signed [stsr_pkg::KEY_W-1:0] i_left_key,
    input  logic signed [stsr_pkg::KEY_W-1:0] i_left_value,
    input  logic                            i_left_ins,
    input  logic signed [stsr_pkg::KEY_W-1:0] i_right_key,
    input  logic signed [stsr_pkg::KEY_W-1:0] i_right_value,
    output logic signed [stsr_pkg::KEY_W-1:0] o_key,
    output logic signed [stsr_pkg::KEY_W-1:0] o_value,
    output logic                            o_ins,
    output logic                            o_lt,
    output logic                            o_gt,
    output logic signed [stsr_pkg::KEY_W-1:0] o_sel_key
);
    import stsr_pkg::*;

    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] r_value;
    logic                    w_held;
    logic                    w_at_or_above_pos;

    // Compare the held value with the broadcast value
    always_comb begin
        w_held            = 32'(i_index) < 32'(i_bcast.count);
        w_at_or_above_pos = 32'(i_index) >= 32'(i_bcast.pos);
        o_lt              = $signed(r_value) < $signed(i_bcast.value);
        o_gt              = $signed(r_value) > $signed(i_bcast.value);
        // Slot lies at or after the insert point: empty, or holds a larger value
        o_ins             = !w_held || o_gt;
    end

    // Shift up from the left on insert, down from the right on remove
    always_ff @(posedge i_clk) begin
        if (i_bcast.shift_ins) begin
            if (i_left_ins) begin
                r_key   <= i_left_key;
                r_value <= i_left_value;
            end else if (o_ins) begin
                r_key   <= i_bcast.key;
                r_value <= i_bcast.value;
            end
        end else if (i_bcast.shift_rem && w_at_or_above_pos) begin
            r_key   <= i_right_key;
            r_value <= i_right_value;
        end
    end

    // Drive the key for read-out only from the selected slot
    assign o_key     = r_key;
    assign o_value   = r_value;
    assign o_sel_key = (i_index == i_bcast.mid) ? r_key : '0;

endmodule

### rtl/stsr_chain.sv
// Row of table cells with neighbour links, plus a registered OR tree that
// reads out the key of the selected cell. Uses stsr_pkg and stsr_cell.
module stsr_chain (
    input  logic                              i_clk,
    input  stsr_pkg::t_bcast                  i_bcast,
    output stsr_pkg::t_flags                  o_flags,
    output logic signed [stsr_pkg::KEY_W-1:0] o_found_key
);
    import stsr_pkg::*;

    logic signed [KEY_W-1:0] w_key     [CAPACITY];
    logic signed [KEY_W-1:0] w_value   [CAPACITY];
    logic                    w_ins     [CAPACITY];
    logic signed [KEY_W-1:0] w_sel     [CAPACITY];
    logic signed [KEY_W-1:0] w_sel_pad [NUM_GROUPS*GROUP_SIZE];
    logic signed [KEY_W-1:0] n_grp     [NUM_GROUPS];
    logic signed [KEY_W-1:0] r_grp     [NUM_GROUPS];

    // Build the row; the first cell has no left neighbour, the last one
    // feeds itself on remove (its slot lies beyond the count afterwards)
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic signed [KEY_W-1:0] w_lk;
        logic signed [KEY_W-1:0] w_lv;
        logic                    w_li;
        logic signed [KEY_W-1:0] w_rk;
        logic signed [KEY_W-1:0] w_rv;

        if (k == 0) begin : g_first
            assign w_lk = '0;
            assign w_lv = '0;
            assign w_li = 1'b0;
        end else begin : g_mid_left
            assign w_lk = w_key[k-1];
            assign w_lv = w_value[k-1];
            assign w_li = w_ins[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign w_rk = w_key[k];
            assign w_rv = w_value[k];
        end else begin : g_mid_right
            assign w_rk = w_key[k+1];
            assign w_rv = w_value[k+1];
        end

        stsr_cell u_cell (
            .i_clk         (i_clk),
            .i_index       (IW'(k)),
            .i_bcast       (i_bcast),
            .i_left_key    (w_lk),
            .i_left_value  (w_lv),
            .i_left_ins    (w_li),
            .i_right_key   (w_rk),
            .i_right_value (w_rv),
            .o_key         (w_key[k]),
            .o_value       (w_value[k]),
            .o_ins         (w_ins[k]),
            .o_lt          (o_flags.lt[k]),
            .o_gt          (o_flags.gt[k]),
            .o_sel_key     (w_sel[k])
        );
    end

    // Pad the read-out row to whole groups
    for (genvar k = 0; k < NUM_GROUPS*GROUP_SIZE; k++) begin : g_pad
        if (k < CAPACITY) begin : g_real
            assign w_sel_pad[k] = w_sel[k];
        end else begin : g_zero
            assign w_sel_pad[k] = '0;
        end
    end

    // First tree level: OR each group of cells
    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < GROUP_SIZE; j++) begin
                n_grp[g] = n_grp[g] | w_sel_pad[g*GROUP_SIZE + j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            r_grp[g] <= n_grp[g];
        end
    end

    // Second tree level: OR the registered groups
    always_comb begin
        o_found_key = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            o_found_key = o_found_key | r_grp[g];
        end
    end

endmodule

### rtl/stsr_ctrl.sv
// Sequencer for the sorted table: takes transactions, drives the cell
// broadcast, steps the binary search and holds results. Uses stsr_pkg.
`include "sorted_table_insert_remove_search_top_assert.svh"
module stsr_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    stsr_in_if.sink                           i_in,
    stsr_out_if.source                        o_out,
    output stsr_pkg::t_bcast                  o_bcast,
    input  stsr_pkg::t_flags                  i_flags,
    input  logic signed [stsr_pkg::KEY_W-1:0] i_found_key
);
    import stsr_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EXEC    = 3'd1;
    localparam logic [2:0] S_SEARCH  = 3'd2;
    localparam logic [2:0] S_READ    = 3'd3;
    localparam logic [2:0] S_COLLECT = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    logic [2:0]              r_state,     n_state;
    logic [1:0]              r_op,        n_op;
    logic signed [KEY_W-1:0] r_key,       n_key;
    logic signed [KEY_W-1:0] r_value,     n_value;
    logic [POS_W-1:0]        r_pos,       n_pos;
    logic [CW-1:0]           r_count,     n_count;
    logic [CW-1:0]           r_lo,        n_lo;
    logic [CW-1:0]           r_hi_ex,     n_hi_ex;
    logic [IW-1:0]           r_mid,       n_mid;
    logic                    r_out_valid, n_out_valid;
    t_result                 r_out,       n_out;
    t_result                 r_pend,      n_pend;

    logic          w_accept;
    logic          w_slot_free;
    logic          w_not_full;
    logic          w_pos_ok;
    logic          w_shift_ins;
    logic          w_shift_rem;
    logic [CW:0]   w_sum;
    logic [IW-1:0] w_mid;
    logic          w_finish;
    t_result       w_res;
    logic [31:0]   w_mid32;

    assign w_accept    = i_in.valid && i_in.ready;
    assign w_slot_free = !r_out_valid || o_out.ready;
    assign w_not_full  = 32'(r_count) < CAPACITY;
    assign w_pos_ok    = 32'(r_pos) < 32'(r_count);
    assign w_shift_ins = (r_state == S_EXEC) && (r_op == OP_INSERT) && w_not_full;
    assign w_shift_rem = (r_state == S_EXEC) && (r_op == OP_REMOVE) && w_pos_ok;

    // Midpoint floor((lo + hi) / 2) with hi = hi_ex - 1
    assign w_sum = (CW+1)'(r_lo) + (CW+1)'(r_hi_ex) - (CW+1)'(1);
    assign w_mid = w_sum[IW:1];

    // Next state, search bounds and result
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key       = r_key;
        n_value     = r_value;
        n_pos       = r_pos;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi_ex     = r_hi_ex;
        n_mid       = r_mid;
        n_out       = r_out;
        n_pend      = r_pend;
        n_out_valid = r_out_valid;
        w_finish    = 1'b0;
        w_res       = '0;

        // Drop the output once taken
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op    = i_in.op;
                    n_key   = i_in.entry_key;
                    n_value = i_in.entry_value;
                    n_pos   = i_in.position;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_op)
                    OP_INSERT: begin
                        w_finish = 1'b1;
                        w_res.ok = w_not_full;
                        if (w_not_full) begin
                            n_count = r_count + CW'(1);
                        end
                    end
                    OP_REMOVE: begin
                        w_finish = 1'b1;
                        w_res.ok = w_pos_ok;
                        if (w_pos_ok) begin
                            n_count = r_count - CW'(1);
                        end
                    end
                    OP_SEARCH: begin
                        n_lo    = '0;
                        n_hi_ex = r_count;
                        n_state = S_SEARCH;
                    end
                    default: begin
                        w_finish = 1'b1;
                    end
                endcase
            end
            S_SEARCH: begin
                if (r_lo >= r_hi_ex) begin
                    w_finish = 1'b1;
                end else if (i_flags.lt[w_mid]) begin
                    n_lo = CW'(w_mid) + CW'(1);
                end else if (i_flags.gt[w_mid]) begin
                    n_hi_ex = CW'(w_mid);
                end else begin
                    n_mid   = w_mid;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_COLLECT;
            end
            S_COLLECT: begin
                w_finish          = 1'b1;
                w_res.ok          = 1'b1;
                w_res.found_key   = i_found_key;
                w_res.found_value = r_value;
                w_res.found_position = w_mid32[POS_W-1:0];
            end
            S_DONE: begin
                if (w_slot_free) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Hand the result to the output register, or hold it until free
        w_res.entry_count = CNT_W'(n_count);
        if (w_finish) begin
            if (w_slot_free) begin
                n_out       = w_res;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end else begin
                n_pend  = w_res;
                n_state = S_DONE;
            end
        end
    end

    assign w_mid32 = 32'(r_mid);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Transaction payload, search bounds and results
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_key   <= n_key;
        r_value <= n_value;
        r_pos   <= n_pos;
        r_lo    <= n_lo;
        r_hi_ex <= n_hi_ex;
        r_mid   <= n_mid;
        r_out   <= n_out;
        r_pend  <= n_pend;
    end

    // Broadcast to the cells
    always_comb begin
        o_bcast.shift_ins = w_shift_ins;
        o_bcast.shift_rem = w_shift_rem;
        o_bcast.key       = r_key;
        o_bcast.value     = r_value;
        o_bcast.pos       = r_pos;
        o_bcast.count     = r_count;
        o_bcast.mid       = r_mid;
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.ok             = r_out.ok;
    assign o_out.found_key      = r_out.found_key;
    assign o_out.found_value    = r_out.found_value;
    assign o_out.found_position = r_out.found_position;
    assign o_out.entry_count    = r_out.entry_count;

    `STSR_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, w_accept, r_state == S_EXEC)
    `STSR_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, w_shift_ins, r_count == $past(r_count) + CW'(1))
    `STSR_ASSERT_NEXT(a_remove_shrinks, i_clk, i_rst_n, w_shift_rem, r_count == $past(r_count) - CW'(1))
    `STSR_ASSERT_IMPLY(a_bounds_ordered, i_clk, i_rst_n, r_state == S_SEARCH, r_hi_ex <= r_count)

endmodule

### rtl/sorted_table_insert_remove_search_top.sv
// Top level of the sorted (key, value) table: sequencer plus cell chain.
// Depends on stsr_pkg, stsr_if, stsr_ctrl and stsr_chain.
//
//  channel | dir | fields                                                      | accepted
//  i_in    | in  | op, entry_key, entry_value, position                        | valid & ready
//  o_out   | out | ok, found_key, found_value, found_position, entry_count     | valid & ready
//
// Insert, remove and unused ops are accepted in S_IDLE and finish in S_EXEC,
// in which every cell shifts or holds at once.
// Search runs at most clog2(CAPACITY) + 1 binary-search steps (one flag lookup
// per cycle), then on a hit a two-level registered key read-out.
// Reset clears the count and control state; cell contents are not cleared.
// A finished result waits in the output register, a second one in a hold register;
// a new transaction is taken only while the sequencer is idle.
module sorted_table_insert_remove_search_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stsr_in_if.sink     i_in,
    stsr_out_if.source  o_out
);
    import stsr_pkg::*;

    t_bcast                  w_bcast;
    t_flags                  w_flags;
    logic signed [KEY_W-1:0] w_found_key;

    stsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_bcast     (w_bcast),
        .i_flags     (w_flags),
        .i_found_key (w_found_key)
    );

    stsr_chain u_chain (
        .i_clk       (i_clk),
        .i_bcast     (w_bcast),
        .o_flags     (w_flags),
        .o_found_key (w_found_key)
    );

endmodule
